// ===== sv/bdl_pkg.sv =====
// bdl_pkg: shared constants, word types and action codes for the bounded deque list
// no dependencies; imported by bdl_ctrl, bdl_datapath and bounded_deque_list_core
`default_nettype none

package bdl_pkg;

  // storage geometry
  localparam int CAPACITY  = 256;
  localparam int ELEM_BITS = 32;
  localparam int PTR_W     = $clog2(CAPACITY);
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int SUM_W     = CNT_W + 1;

  // fixed field widths of the words on the ports
  localparam int ACTION_W = 3;
  localparam int VALUE_W  = 32;
  localparam int INDEX_W  = 8;
  localparam int COUNT_W  = 9;
  localparam int STATUS_W = 2;
  localparam int CMP_W    = (CNT_W > INDEX_W) ? CNT_W : INDEX_W;

  typedef logic [PTR_W-1:0]     ptr_t;
  typedef logic [CNT_W-1:0]     cnt_t;
  typedef logic [SUM_W-1:0]     sum_t;
  typedef logic [CMP_W-1:0]     cmp_t;
  typedef logic [ELEM_BITS-1:0] elem_t;
  typedef logic [VALUE_W-1:0]   value_t;
  typedef logic [INDEX_W-1:0]   index_t;
  typedef logic [COUNT_W-1:0]   count_t;
  typedef logic [STATUS_W-1:0]  status_t;

  typedef enum logic [ACTION_W-1:0] {
    ACT_NONE     = 3'd0,
    ACT_INS_HEAD = 3'd1,
    ACT_INS_TAIL = 3'd2,
    ACT_REM_HEAD = 3'd3,
    ACT_REM_TAIL = 3'd4
  } action_t;

  localparam status_t ST_DONE  = 2'd0;
  localparam status_t ST_FULL  = 2'd1;
  localparam status_t ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    value_t              value;
    index_t              read_index;
  } in_item_t;

  typedef struct packed {
    count_t  count;
    status_t status;
    value_t  head_value;
    value_t  tail_value;
    value_t  indexed_value;
    logic    index_valid;
  } out_item_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;      // apply the action of the accepted word
    logic rd_ends;   // read head and tail slots
    logic rd_index;  // capture head/tail, read indexed slot
    logic load_out;  // load the result word and strobe it
  } bdl_cmd_t;

endpackage

`default_nettype wire

// ===== sv/bdl_ctrl.sv =====
// bdl_ctrl: sequencing state machine for the bounded deque list
// depends on bdl_pkg (command struct)
`default_nettype none

module bdl_ctrl (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              start,
  output logic             busy,
  output bdl_pkg::bdl_cmd_t cmd
);
  import bdl_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD_ENDS,
    S_RD_INDEX,
    S_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          state_nxt = S_RD_ENDS;
        end
      end
      S_RD_ENDS:  state_nxt = S_RD_INDEX;
      S_RD_INDEX: state_nxt = S_OUT;
      S_OUT:      state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      busy_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      busy_r  <= (state_nxt != S_IDLE);
    end
  end

  always_comb begin
    cmd.exec     = (state_r == S_IDLE) && start;
    cmd.rd_ends  = (state_r == S_RD_ENDS);
    cmd.rd_index = (state_r == S_RD_INDEX);
    cmd.load_out = (state_r == S_OUT);
  end

  assign busy = busy_r;

  a_accept_busy : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> busy && cmd.rd_ends)
    else $error("accepted word did not start the read sequence");

  a_busy_state : assert property (@(posedge clk) disable iff (!rst_n)
    busy == (state_r != S_IDLE))
    else $error("busy disagrees with controller state");

  a_out_idle : assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |=> !busy)
    else $error("controller not idle after result load");

endmodule

`default_nettype wire

// ===== sv/bdl_datapath.sv =====
// bdl_datapath: circular element store, head/count registers and result assembly
// depends on bdl_pkg (types, action and status codes, command struct)
`default_nettype none

module bdl_datapath (
  input  wire                 clk,
  input  wire                 rst_n,
  input  bdl_pkg::bdl_cmd_t   cmd,
  input  bdl_pkg::in_item_t   in_item,
  output logic                out_strobe,
  output bdl_pkg::out_item_t  out_item
);
  import bdl_pkg::*;

  // slot of the element at offset off from base, modulo CAPACITY
  function automatic ptr_t slot_of(input ptr_t base, input cnt_t off);
    sum_t sum;
    sum = sum_t'(base) + sum_t'(off);
    if (sum >= sum_t'(CAPACITY)) begin
      sum = sum - sum_t'(CAPACITY);
    end
    return sum[PTR_W-1:0];
  endfunction

  elem_t   mem [CAPACITY];
  elem_t   rd_a_q, rd_b_q;

  ptr_t    head_r, head_nxt;
  cnt_t    count_r, count_nxt;
  status_t status_r, status_nxt;
  index_t  idx_r;
  elem_t   head_val_r, tail_val_r;
  out_item_t out_r;
  logic    out_valid_r;

  logic    full, empty, idx_ok, wr_en, rd_en;
  ptr_t    wr_addr, rd_a_addr, rd_b_addr;
  cnt_t    idx_off, tail_off;

  assign full  = (count_r == cnt_t'(CAPACITY));
  assign empty = (count_r == '0);

  // action decode
  always_comb begin
    head_nxt   = head_r;
    count_nxt  = count_r;
    status_nxt = ST_DONE;
    wr_en      = 1'b0;
    wr_addr    = head_r;
    case (in_item.action)
      ACT_INS_HEAD: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          head_nxt  = (head_r == '0) ? ptr_t'(CAPACITY - 1) : head_r - 1'b1;
          wr_addr   = head_nxt;
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_INS_TAIL: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          wr_addr   = slot_of(head_r, count_r);
          wr_en     = 1'b1;
          count_nxt = count_r + 1'b1;
        end
      end
      ACT_REM_HEAD: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          head_nxt  = slot_of(head_r, cnt_t'(1));
          count_nxt = count_r - 1'b1;
        end
      end
      ACT_REM_TAIL: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = ST_DONE;
      end
    endcase
  end

  // read addresses
  assign idx_ok    = (cmp_t'(idx_r) < cmp_t'(count_r));
  assign idx_off   = idx_ok ? cnt_t'(idx_r) : '0;
  assign tail_off  = empty ? '0 : count_r - 1'b1;
  assign rd_a_addr = cmd.rd_index ? slot_of(head_r, idx_off) : head_r;
  assign rd_b_addr = slot_of(head_r, tail_off);
  assign rd_en     = cmd.rd_ends || cmd.rd_index;

  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      mem[wr_addr] <= elem_t'(in_item.value);
    end
    if (rd_en) begin
      rd_a_q <= mem[rd_a_addr];
      rd_b_q <= mem[rd_b_addr];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.exec) begin
        head_r  <= head_nxt;
        count_r <= count_nxt;
      end
      out_valid_r <= cmd.load_out;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      idx_r    <= in_item.read_index;
    end
    if (cmd.rd_index) begin
      head_val_r <= empty ? '0 : rd_a_q;
      tail_val_r <= empty ? '0 : rd_b_q;
    end
    if (cmd.load_out) begin
      out_r.count         <= count_t'(count_r);
      out_r.status        <= status_r;
      out_r.head_value    <= value_t'(head_val_r);
      out_r.tail_value    <= value_t'(tail_val_r);
      out_r.indexed_value <= idx_ok ? value_t'(rd_a_q) : '0;
      out_r.index_valid   <= idx_ok;
    end
  end

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cnt_t'(CAPACITY))
    else $error("element count above capacity");

  a_head_bound : assert property (@(posedge clk) disable iff (!rst_n)
    sum_t'(head_r) < sum_t'(CAPACITY))
    else $error("head pointer outside the store");

  a_insert_count : assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.exec && wr_en) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not grow the count");

  a_strobe_single : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe held for two cycles");

endmodule

`default_nettype wire

// ===== sv/bounded_deque_list_core.sv =====
// bounded_deque_list_core: bounded double-ended list, one action per command word
// depends on bdl_pkg, bdl_ctrl and bdl_datapath
// sequence: exec on the accepting edge, two store reads, the result load, then the result strobe
// a new word is taken only once the last one is through, as the two-read-port store takes head/tail
// then the indexed slot; busy stays high through the result load; the receiver cannot stall
// reset: synchronous active-low rst_n empties the list (count and head pointer cleared)
`default_nettype none

module bounded_deque_list_core (
  input  wire                 clk,
  input  wire                 rst_n,
  // command side: a word is taken when start is high and busy is low
  input  wire                 start,
  output logic                busy,
  input  bdl_pkg::in_item_t   in_item,
  // result side: one word per command, valid for the single cycle of out_strobe
  output logic                out_strobe,
  output bdl_pkg::out_item_t  out_item
);
  import bdl_pkg::*;

  // controller to datapath command bundle
  bdl_cmd_t cmd;

  // sequencer: idle, read head/tail, read indexed slot, load result
  bdl_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // circular store with head pointer and count; the action is applied in the
  // accepting cycle, the reported elements are read back after it
  bdl_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

`default_nettype wire
